// ----- sv/clook_pkg.sv -----
`default_nettype none

package clook_pkg;

    localparam int CYL_W            = 16;
    localparam int MAX_REQUESTS_DEF = 16;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } t_in_item;

    typedef struct packed {
        logic [CYL_W-1:0] service_cylinder;
        logic             last_result;
        logic             overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic walk_clr;
        logic skip_step;
        logic emit;
        logic batch_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic skip_more;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/clook_dp.sv -----
`default_nettype none

module clook_dp
    import clook_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CYL_W-1:0] i_cfg_data,
    input  wire t_in_item         i_in_data,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);

    logic [CYL_W-1:0] r_cell [MAX_REQUESTS];
    logic [CYL_W-1:0] n_cell [MAX_REQUESTS];
    logic [CW-1:0]    r_count, r_rot_cnt, r_emit_cnt;
    logic             r_dropped;
    logic [CYL_W-1:0] r_head;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [MAX_REQUESTS-1:0] take;
    logic [CW-1:0]    count_m1;
    logic             full;
    logic             rotate;

    assign full     = (r_count == CW'(MAX_REQUESTS));
    assign count_m1 = r_count - CW'(1);
    assign rotate   = i_cmd.skip_step | i_cmd.emit;

    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            take[i] = (CW'(i) >= r_count) || (i_in_data.request_cylinder > r_cell[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.insert && !full) begin
                if (i == 0) begin
                    if (take[0]) n_cell[0] = i_in_data.request_cylinder;
                end else if (take[(i > 0) ? i - 1 : i]) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : i];
                end else if (take[i]) begin
                    n_cell[i] = i_in_data.request_cylinder;
                end
            end else if (rotate) begin
                if (CW'(i) == count_m1) begin
                    n_cell[i] = r_cell[0];
                end else if (i < MAX_REQUESTS - 1) begin
                    n_cell[i] = r_cell[(i < MAX_REQUESTS - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (i_cmd.emit) begin
            r_out.service_cylinder <= r_cell[0];
            r_out.last_result      <= o_status.emit_last;
            r_out.overflow         <= o_status.emit_last & r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_head      <= '0;
            r_rot_cnt   <= '0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_head <= i_cfg_data;
            end
            if (i_cmd.batch_clr) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.insert) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.walk_clr) begin
                r_rot_cnt  <= '0;
                r_emit_cnt <= '0;
            end else begin
                if (i_cmd.skip_step) r_rot_cnt <= r_rot_cnt + CW'(1);
                if (i_cmd.emit) r_emit_cnt <= r_emit_cnt + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.skip_more = (r_rot_cnt < r_count) && (r_cell[0] > r_head);
    assign o_status.emit_last = (r_emit_cnt == count_m1);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REQUESTS))
        else $error("request count exceeds store depth");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> full)
        else $error("drop flag set while store not full");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("beat loaded over a pending beat");

    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_status.emit_last) |=> (r_count == '0) && !r_dropped)
        else $error("batch state not cleared after final beat");

    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.skip_step |-> (r_rot_cnt < r_count))
        else $error("skip walk past stored requests");

endmodule

`default_nettype wire

// ----- sv/clook_ctrl.sv -----
`default_nettype none

module clook_ctrl
    import clook_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_last,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_last) n_state = ST_SKIP;
            end
            ST_SKIP: begin
                if (!i_status.skip_more) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready     = 1'b1;
                o_cmd.insert   = i_in_valid;
                o_cmd.walk_clr = 1'b1;
            end
            ST_SKIP: begin
                o_cmd.skip_step = i_status.skip_more;
            end
            ST_EMIT: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.batch_clr = i_status.out_free & i_status.emit_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.emit && !o_cmd.skip_step)
        else $error("input taken while ordering or emitting");

endmodule

`default_nettype wire

// ----- sv/circular_look_disk_order.sv -----
// Channel  | Dir | Handshake                  | Beat
// request  | in  | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
// service  | out | o_out_valid / i_out_ready  | o_out_data (t_out_item)
// head cfg | in  | i_cfg_we                   | i_cfg_data
//
// Each request is inserted into a sorted register row as it is accepted.
// After the final request the row is rotated once per stored request above the head,
// then one beat is emitted per stored request, one per cycle while the output is ready.
// Input is refused from the final request until the last beat of the batch is loaded.
// Reset clears the batch count, the drop flag, the head position and the output valid.

`default_nettype none

module circular_look_disk_order
    import clook_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CYL_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    clook_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last_request),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    clook_dp #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- tb/circular_look_disk_order_test.sv -----
`timescale 1ns / 100ps

module circular_look_disk_order_test;
    import clook_pkg::*;

    localparam int STORE_DEPTH  = MAX_REQUESTS_DEF;
    localparam int IDLE_PCT     = 28;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS = 300;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CYL_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;

    logic [CYL_W-1:0] head_cyl;
    logic [CYL_W-1:0] pending_cyl [STORE_DEPTH];
    int               pending_count;
    bit               pending_dropped;
    t_out_item        service_order_q [$];
    t_out_item        expected_beat;
    int unsigned      error_count;
    int unsigned      stall_cycles;
    bit               no_idle;

    circular_look_disk_order dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Adds one request to the pending batch; the final one yields the whole service order.
    task automatic schedule_request(input logic [CYL_W-1:0] cyl, input logic last);
        logic [CYL_W-1:0] sorted_cyl [STORE_DEPTH];
        logic [CYL_W-1:0] service_cyl [STORE_DEPTH];
        logic [CYL_W-1:0] key;
        t_out_item        beat;
        int               split;
        int               pos;
        int               i;
        int               j;
        if (pending_count < STORE_DEPTH) begin
            pending_cyl[pending_count] = cyl;
            pending_count++;
        end else begin
            pending_dropped = 1'b1;
        end
        if (!last) return;
        for (i = 0; i < pending_count; i++) begin
            key = pending_cyl[i];
            j = i;
            while (j > 0 && sorted_cyl[j-1] > key) begin
                sorted_cyl[j] = sorted_cyl[j-1];
                j--;
            end
            sorted_cyl[j] = key;
        end
        split = 0;
        while (split < pending_count && sorted_cyl[split] <= head_cyl) split++;
        pos = 0;
        for (i = split - 1; i >= 0; i--) begin
            service_cyl[pos] = sorted_cyl[i];
            pos++;
        end
        for (i = pending_count - 1; i >= split; i--) begin
            service_cyl[pos] = sorted_cyl[i];
            pos++;
        end
        for (i = 0; i < pos; i++) begin
            beat.service_cylinder = service_cyl[i];
            beat.last_result      = (i == pos - 1);
            beat.overflow         = (i == pos - 1) && pending_dropped;
            service_order_q.push_back(beat);
        end
        pending_count   = 0;
        pending_dropped = 1'b0;
    endtask

    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
        t_in_item req;
        req.request_cylinder = cyl;
        req.last_request     = last;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        schedule_request(cyl, last);
    endtask

    task automatic send_batch(input logic [CYL_W-1:0] cyls [$]);
        int i;
        for (i = 0; i < cyls.size(); i++) send_request(cyls[i], i == cyls.size() - 1);
    endtask

    // The head is only moved once the previous service order has fully drained.
    task automatic set_head(input logic [CYL_W-1:0] value);
        i_in_valid <= 1'b0;
        while (service_order_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        head_cyl = value;
    endtask

    function automatic logic [CYL_W-1:0] pick_head();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return CYL_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [CYL_W-1:0] pick_cylinder(input logic [CYL_W-1:0] prev);
        case ($urandom_range(4))
            0:       return CYL_W'($urandom_range(16'hFFFF));
            1:       return head_cyl + CYL_W'($urandom_range(6)) - CYL_W'(3);
            2:       return prev;
            3:       return ($urandom_range(1) == 1) ? '1 : '0;
            default: return head_cyl;
        endcase
    endfunction

    task automatic random_batch(input int size);
        logic [CYL_W-1:0] batch [$];
        logic [CYL_W-1:0] cyl;
        int               i;
        cyl = CYL_W'($urandom_range(16'hFFFF));
        for (i = 0; i < size; i++) begin
            cyl = pick_cylinder(cyl);
            batch.push_back(cyl);
        end
        send_batch(batch);
    endtask

    task automatic test_head_at_zero();
        set_head('0);
        send_batch('{16'd0, 16'hFFFF, 16'd1, 16'h8000});
        send_batch('{16'd0});
        send_batch('{16'h1234});
    endtask

    task automatic test_head_at_top();
        set_head('1);
        send_batch('{16'hFFFF, 16'd0, 16'd300, 16'hFFFE, 16'd300});
    endtask

    task automatic test_duplicates_around_head();
        set_head(16'd1000);
        send_batch('{16'd1000, 16'd1001, 16'd999, 16'd1000, 16'd1001, 16'd5, 16'd64000});
    endtask

    task automatic test_store_full();
        set_head(16'h4000);
        random_batch(STORE_DEPTH);
        random_batch(STORE_DEPTH + 1);
        random_batch(STORE_DEPTH + 4);
    endtask

    task automatic test_random_batches();
        int sent;
        int batch_no;
        int size;
        sent     = 0;
        batch_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (batch_no % 4 == 0) set_head(pick_head());
            no_idle = (batch_no >= 12 && batch_no < 20);
            if ($urandom_range(9) == 0) size = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1);
            else size = $urandom_range(STORE_DEPTH, 1);
            random_batch(size);
            sent += size;
            batch_no++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (service_order_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual %p", $time, o_out_data);
                    error_count++;
                end else begin
                    expected_beat = service_order_q.pop_front();
                    if (o_out_data.service_cylinder !== expected_beat.service_cylinder) begin
                        $display("%0t: service_cylinder expected %0d, actual %0d", $time,
                                 expected_beat.service_cylinder, o_out_data.service_cylinder);
                        error_count++;
                    end
                    if (o_out_data.last_result !== expected_beat.last_result) begin
                        $display("%0t: last_result expected %0b, actual %0b", $time,
                                 expected_beat.last_result, o_out_data.last_result);
                        error_count++;
                    end
                    if (o_out_data.overflow !== expected_beat.overflow) begin
                        $display("%0t: overflow expected %0b, actual %0b", $time,
                                 expected_beat.overflow, o_out_data.overflow);
                        error_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        head_cyl        = '0;
        pending_count   = 0;
        pending_dropped = 1'b0;
        error_count     = 0;
        stall_cycles    = 0;
        no_idle         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_head_at_zero();
        test_head_at_top();
        test_duplicates_around_head();
        test_store_full();
        test_random_batches();
        i_in_valid <= 1'b0;
        while (service_order_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/clook_pkg.sv
sv/clook_dp.sv
sv/clook_ctrl.sv
sv/circular_look_disk_order.sv
tb/circular_look_disk_order_test.sv
